>>> rtl/assert_macros.svh
// Assertion macros used by the converter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define S2G_ASSERT_IMP(label, clk_sig, rst_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication that also holds through reset.
`define S2G_ASSERT_NEXT(label, clk_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/s2g_pkg.sv
// Constants, tables and table builders for the sRGB to gray converter.
package s2g_pkg;

  localparam int FracBits = 16;
  localparam int ChanW    = 8;
  localparam int GrayW    = 8;
  localparam int TabDepth = 1 << ChanW;
  localparam int LinW     = FracBits + 1;
  localparam int WtW      = FracBits;
  localparam int ProdW    = 2 * FracBits + 1;
  localparam int LumW     = FracBits + 1;

  localparam int QB = 60;
  localparam logic [63:0] QOne    = 64'd1 << QB;
  localparam logic [63:0] One     = 64'd1 << FracBits;
  localparam logic [63:0] SegDen  = 64'd269025;
  localparam int          Shift   = QB - FracBits;

  localparam logic [63:0] WtRedW  = (64'd2126 * One + 64'd5000) / 64'd10000;
  localparam logic [63:0] WtBlueW = (64'd722 * One + 64'd5000) / 64'd10000;
  localparam logic [63:0] WtGrnW  = One - WtRedW - WtBlueW;
  localparam logic [WtW-1:0] WtRed   = WtRedW[WtW-1:0];
  localparam logic [WtW-1:0] WtBlue  = WtBlueW[WtW-1:0];
  localparam logic [WtW-1:0] WtGreen = WtGrnW[WtW-1:0];

  localparam logic [ProdW-1:0] RoundHalf = ProdW'(1) << (FracBits - 1);
  localparam logic [LumW-1:0]  LumMax    = LumW'(1) << FracBits;

  typedef logic [LinW-1:0] lin_tab_t [TabDepth];
  typedef logic [LumW-1:0] thr_tab_t [TabDepth];

  // floor(a * b / 2^QB)
  function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[QB+63:QB];
  endfunction

  // floor(n * 2^QB / SegDen), n <= SegDen
  function automatic logic [63:0] qdiv(input logic [63:0] n);
    logic [63:0] q;
    logic [63:0] r;
    q = n / SegDen;
    r = n % SegDen;
    for (int i = 0; i < QB; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= SegDen) begin
        r = r - SegDen;
        q = q | 64'd1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] qpow5(input logic [63:0] r);
    logic [63:0] r2;
    r2 = qmul(r, r);
    return qmul(qmul(r2, r2), r);
  endfunction

  // largest r with r^5 <= t
  function automatic logic [63:0] qroot5(input logic [63:0] t);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    lo = 64'd0;
    hi = QOne;
    while (lo < hi) begin
      mid = lo + ((hi - lo + 64'd1) >> 1);
      if (qpow5(mid) <= t) lo = mid;
      else hi = mid - 64'd1;
    end
    return lo;
  endfunction

  // ((k/255 + 0.055) / 1.055)^2.4 in Q0.QB
  function automatic logic [63:0] pow_part(input int k);
    logic [63:0] x;
    logic [63:0] x2;
    x  = qdiv(64'd1000 * 64'(k) + 64'd14025);
    x2 = qmul(x, x);
    return qmul(x2, qroot5(x2));
  endfunction

  function automatic logic is_linear(input int k);
    return (64'(k) * 64'd100000) <= (64'd4045 * 64'd255);
  endfunction

  function automatic lin_tab_t build_lin();
    lin_tab_t    tab;
    logic [63:0] v;
    for (int k = 0; k < TabDepth; k++) begin
      if (is_linear(k)) v = (64'd10 * 64'(k) * One + 64'd16473) / 64'd32946;
      else v = (pow_part(k) + (64'd1 << (Shift - 1))) >> Shift;
      tab[k] = v[LinW-1:0];
    end
    return tab;
  endfunction

  function automatic thr_tab_t build_thr();
    thr_tab_t    tab;
    logic [63:0] v;
    for (int k = 0; k < TabDepth; k++) begin
      if (is_linear(k)) v = (64'd5 * 64'(k) * One + 64'd16472) / 64'd16473;
      else v = (pow_part(k) + (64'd1 << Shift) - 64'd1) >> Shift;
      tab[k] = v[LumW-1:0];
    end
    return tab;
  endfunction

  localparam lin_tab_t LinTab = build_lin();
  localparam thr_tab_t ThrTab = build_thr();

endpackage

>>> rtl/srgb_to_gray_luminance.sv
// sRGB pixel to Rec.709 gray converter, five register stages.
// Throughput: one pixel per cycle unless out_ready stalls the output register;
// every stage advances when the one after it frees up.
// Stages: linearize lookup, weight multiplies, sum and round, two 4-bit halves of the
// threshold search. Synchronous active-high reset clears every stage valid bit.
`include "assert_macros.svh"

module srgb_to_gray_luminance (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [s2g_pkg::ChanW-1:0]  red,
  input  logic [s2g_pkg::ChanW-1:0]  green,
  input  logic [s2g_pkg::ChanW-1:0]  blue,
  input  logic                       last_pixel,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [s2g_pkg::GrayW-1:0]  gray,
  output logic                       last_out
);

  localparam int HalfBits = s2g_pkg::GrayW / 2;

  // Stage valid bits and advance enables.
  logic a_valid, b_valid, c_valid, d_valid;
  logic a_adv, b_adv, c_adv, d_adv, e_adv;

  // Stage A: linear channel values.
  logic [s2g_pkg::LinW-1:0] lin_red, lin_green, lin_blue;
  logic                     a_last;

  // Stage B: weighted channel products.
  logic [s2g_pkg::ProdW-1:0] prod_red, prod_green, prod_blue;
  logic                      b_last;

  // Stage C: rounded luminance.
  logic [s2g_pkg::ProdW-1:0] acc_next;
  logic [s2g_pkg::LumW-1:0]  lum;
  logic                      c_last;

  // Stage D: upper half of the gray code found.
  logic [s2g_pkg::GrayW-1:0] hi_next, hi_probe;
  logic [s2g_pkg::GrayW-1:0] d_gray;
  logic [s2g_pkg::LumW-1:0]  d_lum;
  logic                      d_last;

  // Output stage: full gray code.
  logic [s2g_pkg::GrayW-1:0] gray_next, lo_probe;

  // Advance a stage when it is empty or the next stage takes its contents;
  // the output register alone parts the result side from the pipeline.
  assign e_adv    = !out_valid || out_ready;
  assign d_adv    = !d_valid || e_adv;
  assign c_adv    = !c_valid || d_adv;
  assign b_adv    = !b_valid || c_adv;
  assign a_adv    = !a_valid || b_adv;
  assign in_ready = a_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      c_valid   <= 1'b0;
      d_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (a_adv) a_valid <= in_valid;
      if (b_adv) b_valid <= a_valid;
      if (c_adv) c_valid <= b_valid;
      if (d_adv) d_valid <= c_valid;
      if (e_adv) out_valid <= d_valid;
    end
  end

  // Stage A: linearize each channel through the decode table.
  always_ff @(posedge clk) begin
    if (a_adv) begin
      lin_red   <= s2g_pkg::LinTab[red];
      lin_green <= s2g_pkg::LinTab[green];
      lin_blue  <= s2g_pkg::LinTab[blue];
      a_last    <= last_pixel;
    end
  end

  // Stage B: one multiplier per channel, weights sum to one in Q0.F.
  always_ff @(posedge clk) begin
    if (b_adv) begin
      prod_red   <= s2g_pkg::ProdW'(lin_red) * s2g_pkg::ProdW'(s2g_pkg::WtRed);
      prod_green <= s2g_pkg::ProdW'(lin_green) * s2g_pkg::ProdW'(s2g_pkg::WtGreen);
      prod_blue  <= s2g_pkg::ProdW'(lin_blue) * s2g_pkg::ProdW'(s2g_pkg::WtBlue);
      b_last     <= a_last;
    end
  end

  // Stage C: sum, round to nearest and drop the fraction.
  assign acc_next = prod_red + prod_green + prod_blue + s2g_pkg::RoundHalf;

  always_ff @(posedge clk) begin
    if (c_adv) begin
      lum    <= acc_next[s2g_pkg::ProdW-1:s2g_pkg::FracBits];
      c_last <= b_last;
    end
  end

  // Stage D: the thresholds rise with the code, so count them by bisection;
  // settle the upper half of the code here.
  always_comb begin
    hi_next  = '0;
    hi_probe = '0;
    for (int i = s2g_pkg::GrayW - 1; i >= HalfBits; i--) begin
      hi_probe = hi_next | (s2g_pkg::GrayW'(1) << i);
      if (lum >= s2g_pkg::ThrTab[hi_probe]) hi_next = hi_probe;
    end
  end

  always_ff @(posedge clk) begin
    if (d_adv) begin
      d_gray <= hi_next;
      d_lum  <= lum;
      d_last <= c_last;
    end
  end

  // Output stage: finish the lower half and hold the result until taken.
  always_comb begin
    gray_next = d_gray;
    lo_probe  = '0;
    for (int i = HalfBits - 1; i >= 0; i--) begin
      lo_probe = gray_next | (s2g_pkg::GrayW'(1) << i);
      if (d_lum >= s2g_pkg::ThrTab[lo_probe]) gray_next = lo_probe;
    end
  end

  always_ff @(posedge clk) begin
    if (e_adv) begin
      gray     <= gray_next;
      last_out <= d_last;
    end
  end

  // A ready output frees the whole chain, so in_ready is high whenever out_ready is.
  `S2G_ASSERT_IMP(a_ready_follows, clk, rst, out_ready, in_ready)
  // Luminance never exceeds one: the weights sum to exactly one.
  `S2G_ASSERT_IMP(a_lum_range, clk, rst, c_valid, lum <= s2g_pkg::LumMax)
  // Reset empties the output register.
  `S2G_ASSERT_NEXT(a_reset_empty, clk, rst, !out_valid)

endmodule

>>> bench/testbench.sv
// Self-checking bench for the sRGB to Rec.709 gray converter with a bit-exact predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ChanW = s2g_pkg::ChanW;
  localparam int GrayW = s2g_pkg::GrayW;
  localparam int FracW = s2g_pkg::FracBits;

  // Power-law part of the decode curve is worked in Q0.60.
  localparam int          PowQ    = 60;
  localparam logic [63:0] PowOne  = 64'd1 << PowQ;
  localparam int          PowDrop = PowQ - FracW;

  localparam int NumDirected        = 20;
  localparam int NumRandom          = 1800;
  localparam int BackpressureAt     = 500;
  localparam int BackpressureCycles = 400;
  localparam int DrainCycles        = 12;

  // One row of the directed table. When known is set, the gray level is typed in
  // here instead of being taken from the predictor.
  typedef struct packed {
    logic [ChanW-1:0] r;
    logic [ChanW-1:0] g;
    logic [ChanW-1:0] b;
    logic             last;
    logic             known;
    logic [GrayW-1:0] gray;
  } pixel_row_t;

  typedef struct {
    logic [GrayW-1:0] gray;
    logic             last;
  } gray_result_t;

  localparam pixel_row_t DirectedRows [NumDirected] = '{
    '{8'd0,   8'd0,   8'd0,   1'b0, 1'b1, 8'd0},    // black
    '{8'd255, 8'd255, 8'd255, 1'b0, 1'b1, 8'd255},  // white: weights sum to one
    '{8'd255, 8'd0,   8'd0,   1'b0, 1'b0, 8'd0},    // pure red
    '{8'd0,   8'd255, 8'd0,   1'b0, 1'b0, 8'd0},    // pure green
    '{8'd0,   8'd0,   8'd255, 1'b0, 1'b0, 8'd0},    // pure blue
    '{8'd1,   8'd1,   8'd1,   1'b0, 1'b0, 8'd0},    // smallest nonzero code
    '{8'd10,  8'd10,  8'd10,  1'b0, 1'b0, 8'd0},    // top of the linear segment
    '{8'd11,  8'd11,  8'd11,  1'b0, 1'b0, 8'd0},    // first code on the power curve
    '{8'd254, 8'd254, 8'd254, 1'b0, 1'b0, 8'd0},    // just below white
    '{8'd128, 8'd128, 8'd128, 1'b1, 1'b0, 8'd0},    // mid gray, end of image
    '{8'd170, 8'd85,  8'd170, 1'b0, 1'b0, 8'd0},    // alternating bit patterns
    '{8'd85,  8'd170, 8'd85,  1'b1, 1'b0, 8'd0},
    '{8'd255, 8'd255, 8'd0,   1'b0, 1'b0, 8'd0},    // yellow
    '{8'd0,   8'd255, 8'd255, 1'b0, 1'b0, 8'd0},    // cyan
    '{8'd255, 8'd0,   8'd255, 1'b1, 1'b0, 8'd0},    // magenta
    '{8'd10,  8'd11,  8'd10,  1'b0, 1'b0, 8'd0},    // straddle the segment boundary
    '{8'd1,   8'd254, 8'd128, 1'b0, 1'b0, 8'd0},
    '{8'd255, 8'd255, 8'd255, 1'b1, 1'b1, 8'd255},  // white with the last flag
    '{8'd0,   8'd0,   8'd0,   1'b1, 1'b1, 8'd0},    // black with the last flag
    '{8'd254, 8'd1,   8'd11,  1'b0, 1'b0, 8'd0}
  };

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_ready;
  logic [ChanW-1:0] red;
  logic [ChanW-1:0] green;
  logic [ChanW-1:0] blue;
  logic             last_pixel;
  logic             out_valid;
  logic             out_ready;
  logic [GrayW-1:0] gray;
  logic             last_out;

  // Predictor tables: linearized channel codes in Q0.16 and the encode thresholds.
  logic [63:0] decode_lut    [256];
  logic [63:0] encode_thresh [256];
  logic [63:0] weight_red;
  logic [63:0] weight_green;
  logic [63:0] weight_blue;

  gray_result_t gray_expected [$];
  int           pixels_sent;
  int           mismatch_count;

  srgb_to_gray_luminance uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .last_pixel (last_pixel),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .gray       (gray),
    .last_out   (last_out)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Truncating Q0.60 product.
  function automatic logic [63:0] q60_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[PowQ +: 64];
  endfunction

  function automatic logic [63:0] q60_pow5(input logic [63:0] v);
    logic [63:0] sq;
    sq = q60_mul(v, v);
    return q60_mul(q60_mul(sq, sq), v);
  endfunction

  // Largest root in [0, 1] whose fifth power stays at or below t. The truncated
  // fifth power is monotonic, so a bit-by-bit search lands on the same value as
  // a bisection would.
  function automatic logic [63:0] q60_root5(input logic [63:0] t);
    logic [63:0] root;
    logic [63:0] trial;
    root = 64'd0;
    for (int bit_pos = PowQ; bit_pos >= 0; bit_pos--) begin
      trial = root | (64'd1 << bit_pos);
      if (trial <= PowOne && q60_pow5(trial) <= t) root = trial;
    end
    return root;
  endfunction

  // ((k/255 + 0.055) / 1.055)^2.4 in Q0.60, as x^2 * x^(2/5).
  function automatic logic [63:0] srgb_curve(input int k);
    logic [127:0] num;
    logic [63:0]  x;
    logic [63:0]  x2;
    num = 128'(1000 * k + 14025) << PowQ;
    x   = 64'(num / 128'd269025);
    x2  = q60_mul(x, x);
    return q60_mul(x2, q60_root5(x2));
  endfunction

  // Weight and round the three linear channels, then count the thresholds reached.
  function automatic logic [GrayW-1:0] predict_gray(input logic [ChanW-1:0] r,
                                                    input logic [ChanW-1:0] g,
                                                    input logic [ChanW-1:0] b);
    logic [63:0] acc;
    logic [63:0] lum;
    int          level;
    acc = weight_red * decode_lut[r] + weight_green * decode_lut[g]
        + weight_blue * decode_lut[b];
    lum = (acc + (64'd1 << (FracW - 1))) >> FracW;
    level = 0;
    for (int k = 1; k < 256; k++)
      if (lum >= encode_thresh[k]) level++;
    return GrayW'(level);
  endfunction

  // Mostly no gap, some short ones, a few long ones.
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 88) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Codes near black, near white and around the linear/curve boundary.
  function automatic logic [ChanW-1:0] extreme_code();
    case ($urandom_range(0, 2))
      0:       return ChanW'($urandom_range(0, 3));
      1:       return ChanW'($urandom_range(252, 255));
      default: return ChanW'($urandom_range(8, 13));
    endcase
  endfunction

  // Small step from a neighboring pixel, clamped to the code range.
  function automatic logic [ChanW-1:0] nudge(input logic [ChanW-1:0] v);
    int t;
    t = int'(v) + $urandom_range(0, 8) - 4;
    if (t < 0) t = 0;
    if (t > 255) t = 255;
    return ChanW'(t);
  endfunction

  // Offer one request and hold it until the converter takes it, then log
  // what the result should be.
  task automatic send_pixel(input logic [ChanW-1:0] r, input logic [ChanW-1:0] g,
                            input logic [ChanW-1:0] b, input logic last,
                            input logic known, input logic [GrayW-1:0] known_gray);
    gray_result_t want;
    red        <= r;
    green      <= g;
    blue       <= b;
    last_pixel <= last;
    in_valid   <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    want.gray = known ? known_gray : predict_gray(r, g, b);
    want.last = last;
    gray_expected.push_back(want);
    pixels_sent++;
  endtask

  // Drop valid for a random gap; every 400 requests, run 80 back to back.
  task automatic idle_sender(input int idx);
    int gap;
    gap = (idx % 400 < 80) ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stimulus: directed table first, then random pixels.
  initial begin : stimulus
    logic [ChanW-1:0] r;
    logic [ChanW-1:0] g;
    logic [ChanW-1:0] b;
    logic [ChanW-1:0] base;
    int               mode;

    in_valid       = 1'b0;
    red            = '0;
    green          = '0;
    blue           = '0;
    last_pixel     = 1'b0;
    rst            = 1'b1;
    pixels_sent    = 0;
    mismatch_count = 0;
    base           = '0;

    // Build the predictor tables; the first eleven codes sit on the linear segment.
    for (int k = 0; k < 256; k++) begin
      if (k * 100000 <= 4045 * 255) begin
        decode_lut[k]    = (64'd10 * 64'(k) * (64'd1 << FracW) + 64'd16473) / 64'd32946;
        encode_thresh[k] = (64'd5 * 64'(k) * (64'd1 << FracW) + 64'd16472) / 64'd16473;
      end else begin
        decode_lut[k]    = (srgb_curve(k) + (64'd1 << (PowDrop - 1))) >> PowDrop;
        encode_thresh[k] = (srgb_curve(k) + (64'd1 << PowDrop) - 64'd1) >> PowDrop;
      end
    end
    weight_red   = (64'd2126 * (64'd1 << FracW) + 64'd5000) / 64'd10000;
    weight_blue  = (64'd722 * (64'd1 << FracW) + 64'd5000) / 64'd10000;
    weight_green = (64'd1 << FracW) - weight_red - weight_blue;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NumDirected; i++) begin
      send_pixel(DirectedRows[i].r, DirectedRows[i].g, DirectedRows[i].b,
                 DirectedRows[i].last, DirectedRows[i].known, DirectedRows[i].gray);
      idle_sender(i + 100);
    end

    for (int i = 0; i < NumRandom; i++) begin
      mode = $urandom_range(0, 99);
      if (mode < 40) begin
        // uniform color
        r = ChanW'($urandom);
        g = ChanW'($urandom);
        b = ChanW'($urandom);
      end else if (mode < 60) begin
        // neutral gray input
        r = ChanW'($urandom);
        g = r;
        b = r;
      end else if (mode < 75) begin
        r = extreme_code();
        g = extreme_code();
        b = extreme_code();
      end else begin
        // smooth image region: stay close to the previous pixel
        if ($urandom_range(0, 15) == 0) base = ChanW'($urandom);
        base = nudge(base);
        r = nudge(base);
        g = nudge(base);
        b = nudge(base);
      end
      send_pixel(r, g, b, $urandom_range(0, 15) == 0, 1'b0, '0);
      idle_sender(i);
    end
    in_valid <= 1'b0;

    // Drain, then watch a little longer for stray results.
    while (gray_expected.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Downstream: random ready pattern, plus one long hold-off while the sender
  // keeps offering, so the pipeline fills and in_ready drops.
  initial begin : receiver
    int  run;
    int  gap;
    logic backpressure_done;
    out_ready = 1'b0;
    backpressure_done = 1'b0;
    wait (rst === 1'b0);
    forever begin
      if (!backpressure_done && pixels_sent >= BackpressureAt) begin
        out_ready <= 1'b0;
        repeat (BackpressureCycles) @(posedge clk);
        backpressure_done = 1'b1;
      end
      out_ready <= 1'b1;
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200) : $urandom_range(1, 30);
      repeat (run) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // Compare each delivered result with the oldest outstanding expectation.
  always @(posedge clk) begin : result_check
    gray_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (gray_expected.size() == 0) begin
        mismatch_count++;
        $display("%0t: result with nothing pending: gray=%0d last_out=%0b",
                 $time, gray, last_out);
      end else begin
        want = gray_expected.pop_front();
        if (gray !== want.gray) begin
          mismatch_count++;
          $display("%0t: gray mismatch: expected %0d, got %0d", $time, want.gray, gray);
        end
        if (last_out !== want.last) begin
          mismatch_count++;
          $display("%0t: last_out mismatch: expected %0b, got %0b",
                   $time, want.last, last_out);
        end
      end
    end
  end

  // Watchdog: a correct run finishes far earlier.
  initial begin : watchdog
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/s2g_pkg.sv
rtl/srgb_to_gray_luminance.sv
bench/testbench.sv
